/* sv/scg_pkg.sv */
// Shared types, constants and exponent tables of the softmax confidence gate.
// Used by scg_div and by the top level; depends on nothing else.
`default_nettype none

package scg_pkg;

  localparam int NUM_LABELS = 6;
  localparam int LOGIT_W    = 12;
  localparam int LBL_W      = 3;
  localparam int Q16_W      = 16;
  localparam int E_W        = 17;
  localparam int SUM_W      = 19;
  localparam int PROD_W     = 2 * E_W;
  localparam int CNT_W      = 32;
  localparam int IDX_W      = $clog2(NUM_LABELS);
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_STR    = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STR0   = 3'd2;

  localparam logic [Q16_W-1:0] THRESH_RST = 16'd22938;
  localparam logic [Q16_W-1:0] MUTED_RST  = 16'd19661;

  localparam logic [E_W-1:0]   ONE_Q16    = 17'd65536;
  localparam logic [PROD_W-1:0] RND_HALF  = 34'd32768;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAX,
    ST_EXP_A,
    ST_EXP_B,
    ST_DIVGO,
    ST_DIV,
    ST_DONE
  } st_e;

  function automatic logic [Q16_W-1:0] str_rst(input logic [IDX_W-1:0] i);
    logic [Q16_W-1:0] v;
    case (i)
      3'd0:    v = 16'd32768;
      3'd1:    v = 16'd45875;
      3'd2:    v = 16'd39322;
      3'd3:    v = 16'd32768;
      3'd4:    v = 16'd42598;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // exp(-k) for the integer part of the distance, Q1.16.
  function automatic logic [E_W-1:0] exp_int(input logic [3:0] k);
    logic [E_W-1:0] v;
    case (k)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // exp(-h/16), Q1.16.
  function automatic logic [E_W-1:0] exp_hi(input logic [3:0] h);
    logic [E_W-1:0] v;
    case (h)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd61565;
      4'd2:    v = 17'd57835;
      4'd3:    v = 17'd54331;
      4'd4:    v = 17'd51039;
      4'd5:    v = 17'd47947;
      4'd6:    v = 17'd45042;
      4'd7:    v = 17'd42313;
      4'd8:    v = 17'd39750;
      4'd9:    v = 17'd37341;
      4'd10:   v = 17'd35079;
      4'd11:   v = 17'd32954;
      4'd12:   v = 17'd30957;
      4'd13:   v = 17'd29081;
      4'd14:   v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

  // exp(-l/256), Q1.16.
  function automatic logic [E_W-1:0] exp_lo(input logic [3:0] l);
    logic [E_W-1:0] v;
    case (l)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd65280;
      4'd2:    v = 17'd65026;
      4'd3:    v = 17'd64772;
      4'd4:    v = 17'd64520;
      4'd5:    v = 17'd64268;
      4'd6:    v = 17'd64018;
      4'd7:    v = 17'd63768;
      4'd8:    v = 17'd63520;
      4'd9:    v = 17'd63272;
      4'd10:   v = 17'd63025;
      4'd11:   v = 17'd62780;
      4'd12:   v = 17'd62535;
      4'd13:   v = 17'd62291;
      4'd14:   v = 17'd62048;
      default: v = 17'd61806;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* sv/scg_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// Depends on scg_pkg for the divisor and quotient widths.
`default_nettype none

module scg_div
  import scg_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [SUM_W+Q16_W-1:0] dividend_i,
  input  wire logic [SUM_W-1:0]       divisor_i,
  output logic                        done_o,
  output logic [Q16_W-1:0]            quotient_o
);

  localparam int CNT_DW = $clog2(Q16_W);
  localparam logic [CNT_DW-1:0] LAST = CNT_DW'(Q16_W - 1);

  // The caller guarantees dividend < divisor * 2^16, so the upper part
  // starts below the divisor and the quotient fits in 16 bits.
  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [Q16_W-1:0]  low_q, low_d;
  logic [SUM_W-1:0]  den_q;
  logic [CNT_DW-1:0] cnt_q;
  logic              busy_q;
  logic [SUM_W:0]    trial;
  logic              qbit;

  always_comb begin
    trial = {rem_q, low_q[Q16_W-1]} - {1'b0, den_q};
    qbit  = ~trial[SUM_W];
    rem_d = qbit ? trial[SUM_W-1:0] : {rem_q[SUM_W-2:0], low_q[Q16_W-1]};
    low_d = {low_q[Q16_W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[SUM_W+Q16_W-1:Q16_W];
      low_q <= dividend_i[Q16_W-1:0];
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  assign done_o     = busy_q && (cnt_q == LAST);
  assign quotient_o = low_q;

endmodule

`default_nettype wire

/* sv/softmax_confidence_gate.sv */
// Top level of the softmax confidence gate: sequencer, shared multiplier,
// configuration registers, counters and output register. Uses scg_pkg and scg_div.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   input    | in_valid_i, in_stall_o, logit_*_i, true_* | in
//   output   | out_valid_o, out_stall_i, result fields   | out
//   config   | cfg_we_i, cfg_idx_i, cfg_wdata_i          | in
//
// Each item passes through these steps in order: the accept, the shared
// compare for the maximum, the shared 17x17 multiplier (two products per
// label), forming the dividend and starting the serial divider, the
// serial divide itself, then the load of the result. The next item is
// taken once the sequencer is back in idle, so no new item enters while
// one is in work; the serial divide is the longest of the steps.
// Reset restores the configuration defaults and clears both counters.
// A stalled result waits in the output register while the next item is
// already being worked on; only the final load waits for that slot.
`default_nettype none

module softmax_confidence_gate
  import scg_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [Q16_W-1:0]    cfg_wdata_i,

  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [LOGIT_W-1:0]  logit_0_i,
  input  wire logic [LOGIT_W-1:0]  logit_1_i,
  input  wire logic [LOGIT_W-1:0]  logit_2_i,
  input  wire logic [LOGIT_W-1:0]  logit_3_i,
  input  wire logic [LOGIT_W-1:0]  logit_4_i,
  input  wire logic [LOGIT_W-1:0]  logit_5_i,
  input  wire logic [LBL_W-1:0]    true_label_i,

  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [LBL_W-1:0]         detected_label_o,
  output logic [Q16_W-1:0]         uncertainty_o,
  output logic [Q16_W-1:0]         strength_o,
  output logic                     is_correct_o,
  output logic                     is_muted_o,
  output logic [CNT_W-1:0]         correct_total_o,
  output logic [CNT_W-1:0]         muted_total_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LABELS - 1);

  st_e state_q, state_d;

  // Configuration registers.
  logic [Q16_W-1:0] thresh_q;
  logic [Q16_W-1:0] muted_q;
  logic [Q16_W-1:0] str_q [NUM_STR];

  // Item and working registers.
  logic signed [LOGIT_W-1:0] lg_q [NUM_LABELS];
  logic [LBL_W-1:0]          truth_q;
  logic signed [LOGIT_W-1:0] mx_q;
  logic [IDX_W-1:0]          det_q;
  logic [IDX_W-1:0]          idx_q;
  logic [E_W-1:0]            t_q;
  logic [SUM_W-1:0]          sum_q;
  logic [CNT_W-1:0]          correct_q, muted_cnt_q;
  logic                      out_valid_q;

  // Sequencer outputs.
  logic accept, div_start, out_load, slot_free;

  // Shared datapath.
  logic signed [LOGIT_W-1:0] lg_sel;
  logic [LOGIT_W:0]          diff;
  logic [LOGIT_W-1:0]        delta;
  logic [E_W-1:0]            mul_a, mul_b;
  logic [PROD_W-1:0]         prod, prod_rnd;
  logic [E_W-1:0]            prod_q16;
  logic [SUM_W+Q16_W-1:0]    dividend;
  logic                      div_done;
  logic [Q16_W-1:0]          quot;

  // Result logic.
  logic             high_unc, is_correct, is_muted;
  logic [Q16_W-1:0] lbl_str, strength;

  assign lg_sel = lg_q[idx_q];
  assign diff   = {mx_q[LOGIT_W-1], mx_q} - {lg_sel[LOGIT_W-1], lg_sel};
  assign delta  = diff[LOGIT_W-1:0];

  // One multiplier serves both table products of every label.
  always_comb begin
    if (state_q == ST_EXP_B) begin
      mul_a = t_q;
      mul_b = exp_lo(delta[3:0]);
    end else begin
      mul_a = exp_int(delta[11:8]);
      mul_b = exp_hi(delta[7:4]);
    end
    prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
    prod_rnd = prod + RND_HALF;
    prod_q16 = prod_rnd[Q16_W+E_W-1:Q16_W];
  end

  // Dividend (S - 1.0) * 2^16 + S / 2; it stays below S * 2^16.
  assign dividend = {sum_q - SUM_W'(ONE_Q16), {Q16_W{1'b0}}}
                  + (SUM_W+Q16_W)'(sum_q[SUM_W-1:1]);

  scg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (sum_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_MAX;
      ST_MAX:   if (idx_q == LAST_IDX) state_d = ST_EXP_A;
      ST_EXP_A: state_d = ST_EXP_B;
      ST_EXP_B: state_d = (idx_q == LAST_IDX) ? ST_DIVGO : ST_EXP_A;
      ST_DIVGO: state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_DONE;
      ST_DONE:  if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE:  in_stall_o = 1'b0;
      ST_DIVGO: div_start  = 1'b1;
      ST_DONE:  out_load   = slot_free;
      default:  in_stall_o = 1'b1;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  // Strength selection and flags for the finished item.
  always_comb begin
    high_unc = quot > thresh_q;
    lbl_str  = muted_q;
    if (det_q <= IDX_W'(NUM_STR - 1)) begin
      lbl_str = str_q[det_q];
    end
    strength   = high_unc ? muted_q : lbl_str;
    is_correct = LBL_W'(det_q) == truth_q;
    is_muted   = high_unc && (strength <= muted_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes; every 3-bit index past the muted value is a
  // per-label strength.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RST;
      muted_q  <= MUTED_RST;
      for (int i = 0; i < NUM_STR; i++) begin
        str_q[i] <= str_rst(IDX_W'(i));
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESH: thresh_q <= cfg_wdata_i;
        CFG_MUTED:  muted_q  <= cfg_wdata_i;
        default:    str_q[IDX_W'(cfg_idx_i - CFG_STR0)] <= cfg_wdata_i;
      endcase
    end
  end

  // Saturating counters and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      correct_q   <= '0;
      muted_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
      if (is_correct && (correct_q != '1)) begin
        correct_q <= correct_q + 1'b1;
      end
      if (is_muted && (muted_cnt_q != '1)) begin
        muted_cnt_q <= muted_cnt_q + 1'b1;
      end
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE:  idx_q <= IDX_W'(1);
        ST_MAX:   idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
        ST_EXP_B: idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
        default:  idx_q <= idx_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lg_q[0] <= logit_0_i;
      lg_q[1] <= logit_1_i;
      lg_q[2] <= logit_2_i;
      lg_q[3] <= logit_3_i;
      lg_q[4] <= logit_4_i;
      lg_q[5] <= logit_5_i;
      truth_q <= true_label_i;
      mx_q    <= logit_0_i;
      det_q   <= '0;
    end
    if (state_q == ST_MAX) begin
      // Strict compare keeps the first maximum.
      if (lg_sel > mx_q) begin
        mx_q  <= lg_sel;
        det_q <= idx_q;
      end
      sum_q <= '0;
    end
    if (state_q == ST_EXP_A) begin
      t_q <= prod_q16;
    end
    if (state_q == ST_EXP_B) begin
      sum_q <= sum_q + SUM_W'(prod_q16);
    end
    if (out_load) begin
      detected_label_o <= LBL_W'(det_q);
      uncertainty_o    <= quot;
      strength_o       <= strength;
      is_correct_o     <= is_correct;
      is_muted_o       <= is_muted;
      correct_total_o  <= (is_correct && (correct_q != '1)) ? correct_q + 1'b1 : correct_q;
      muted_total_o    <= (is_muted && (muted_cnt_q != '1)) ? muted_cnt_q + 1'b1
                                                            : muted_cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // The maximum term is exactly 1.0, so the sum lies in [1.0, NUM_LABELS].
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVGO) |->
      (sum_q >= SUM_W'(ONE_Q16)) && (sum_q <= SUM_W'(NUM_LABELS * 65536)))
    else $error("exponent sum out of range");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAX || state_q == ST_EXP_A || state_q == ST_EXP_B) |->
      (idx_q <= LAST_IDX))
    else $error("label index out of range");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a stalled result");

endmodule

`default_nettype wire

/* sim/softmax_gate_checker.sv */
// Result checker for the softmax confidence gate testbench.
// Mirrors the register writes, predicts each result from the accepted logits
// and compares the block's results in order. Depends on scg_pkg only.

module softmax_gate_checker
  import scg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [Q16_W-1:0]     cfg_wdata_i,

  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [LOGIT_W-1:0]   logit_0_i,
  input  logic [LOGIT_W-1:0]   logit_1_i,
  input  logic [LOGIT_W-1:0]   logit_2_i,
  input  logic [LOGIT_W-1:0]   logit_3_i,
  input  logic [LOGIT_W-1:0]   logit_4_i,
  input  logic [LOGIT_W-1:0]   logit_5_i,
  input  logic [LBL_W-1:0]     true_label_i,

  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [LBL_W-1:0]     detected_label_i,
  input  logic [Q16_W-1:0]     uncertainty_i,
  input  logic [Q16_W-1:0]     strength_i,
  input  logic                 is_correct_i,
  input  logic                 is_muted_i,
  input  logic [CNT_W-1:0]     correct_total_i,
  input  logic [CNT_W-1:0]     muted_total_i,

  output int                   errors_o,
  output int                   pending_o,
  output int                   checked_o
);

  localparam int REPORT_LIMIT = 10;

  typedef logic [NUM_LABELS-1:0][LOGIT_W-1:0] logit_set_t;

  typedef struct packed {
    logic [LBL_W-1:0] label;
    logic [Q16_W-1:0] uncert;
    logic [Q16_W-1:0] strength;
    logic             correct;
    logic             muted;
    logic [CNT_W-1:0] correct_total;
    logic [CNT_W-1:0] muted_total;
  } verdict_t;

  // Register copies and the two running counters, as the block should hold them.
  logic [Q16_W-1:0] thresh_q;
  logic [Q16_W-1:0] muted_q;
  logic [Q16_W-1:0] label_str_q [NUM_STR];
  logic [CNT_W-1:0] correct_cnt;
  logic [CNT_W-1:0] muted_cnt;

  verdict_t pending_verdicts [$];
  verdict_t want;
  verdict_t got;
  verdict_t fresh;
  int       mismatches;
  int       checked;

  // exp(-k) in Q1.16; the tail beyond eleven rounds to zero.
  function automatic logic [63:0] exp_whole(input logic [3:0] k);
    logic [63:0] v;
    case (k)
      4'd0: v = 65536;  4'd1: v = 24109;  4'd2: v = 8869;  4'd3: v = 3263;
      4'd4: v = 1200;   4'd5: v = 442;    4'd6: v = 162;   4'd7: v = 60;
      4'd8: v = 22;     4'd9: v = 8;      4'd10: v = 3;    4'd11: v = 1;
      default: v = 0;
    endcase
    return v;
  endfunction

  // exp(-h/16) in Q1.16.
  function automatic logic [63:0] exp_sixteenth(input logic [3:0] h);
    logic [63:0] v;
    case (h)
      4'd0: v = 65536;   4'd1: v = 61565;   4'd2: v = 57835;   4'd3: v = 54331;
      4'd4: v = 51039;   4'd5: v = 47947;   4'd6: v = 45042;   4'd7: v = 42313;
      4'd8: v = 39750;   4'd9: v = 37341;   4'd10: v = 35079;  4'd11: v = 32954;
      4'd12: v = 30957;  4'd13: v = 29081;  4'd14: v = 27319;  default: v = 25664;
    endcase
    return v;
  endfunction

  // exp(-l/256) in Q1.16.
  function automatic logic [63:0] exp_fine(input logic [3:0] l);
    logic [63:0] v;
    case (l)
      4'd0: v = 65536;   4'd1: v = 65280;   4'd2: v = 65026;   4'd3: v = 64772;
      4'd4: v = 64520;   4'd5: v = 64268;   4'd6: v = 64018;   4'd7: v = 63768;
      4'd8: v = 63520;   4'd9: v = 63272;   4'd10: v = 63025;  4'd11: v = 62780;
      4'd12: v = 62535;  4'd13: v = 62291;  4'd14: v = 62048;  default: v = 61806;
    endcase
    return v;
  endfunction

  // Detection, uncertainty and strength of one item under the current registers.
  // The running totals are filled in by the caller.
  function automatic verdict_t classify_logits(input logit_set_t lg,
                                               input logic [LBL_W-1:0] truth);
    verdict_t                  v;
    logic signed [LOGIT_W-1:0] top;
    logic [LOGIT_W-1:0]        span;
    logic [63:0]               term;
    logic [63:0]               expsum;
    logic [63:0]               u;
    int                        i;
    v = '0;
    top = lg[0];
    for (i = 1; i < NUM_LABELS; i++) begin
      // Strict compare keeps the lowest index on ties.
      if ($signed(lg[i]) > top) begin
        top = lg[i];
        v.label = i[LBL_W-1:0];
      end
    end
    expsum = '0;
    for (i = 0; i < NUM_LABELS; i++) begin
      span = top - lg[i];
      term = (exp_whole(span[11:8]) * exp_sixteenth(span[7:4]) + 64'd32768) >> 16;
      term = (term * exp_fine(span[3:0]) + 64'd32768) >> 16;
      expsum = expsum + term;
    end
    u = ((expsum - 64'd65536) * 64'd65536 + expsum / 2) / expsum;
    if (u > 64'd65535) u = 64'd65535;
    v.uncert = u[Q16_W-1:0];
    if (u > thresh_q) v.strength = muted_q;
    else v.strength = label_str_q[v.label];
    v.correct = (v.label == truth);
    v.muted = (u > thresh_q) && (v.strength <= muted_q);
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q = 16'd22938;
      muted_q = 16'd19661;
      label_str_q[0] = 16'd32768;
      label_str_q[1] = 16'd45875;
      label_str_q[2] = 16'd39322;
      label_str_q[3] = 16'd32768;
      label_str_q[4] = 16'd42598;
      label_str_q[5] = 16'd0;
      correct_cnt = '0;
      muted_cnt = '0;
      pending_verdicts.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_THRESH) thresh_q = cfg_wdata_i;
        else if (cfg_idx_i == CFG_MUTED) muted_q = cfg_wdata_i;
        else if (cfg_idx_i >= CFG_STR0 && cfg_idx_i < CFG_STR0 + NUM_STR)
          label_str_q[cfg_idx_i - CFG_STR0] = cfg_wdata_i;
      end

      if (out_valid_i && !out_stall_i) begin
        got = {detected_label_i, uncertainty_i, strength_i, is_correct_i, is_muted_i,
               correct_total_i, muted_total_i};
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("MISMATCH #%0d at %0t: result with no item outstanding (label %0d)",
                     mismatches, $time, got.label);
        end else begin
          want = pending_verdicts.pop_front();
          checked++;
          if (got.label !== want.label || got.uncert !== want.uncert ||
              got.strength !== want.strength || got.correct !== want.correct ||
              got.muted !== want.muted || got.correct_total !== want.correct_total ||
              got.muted_total !== want.muted_total) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("MISMATCH #%0d at %0t (expected/actual): label %0d/%0d",
                       mismatches, $time, want.label, got.label);
              $display("  uncertainty %0d/%0d strength %0d/%0d correct %0b/%0b muted %0b/%0b",
                       want.uncert, got.uncert, want.strength, got.strength,
                       want.correct, got.correct, want.muted, got.muted);
              $display("  correct_total %0d/%0d muted_total %0d/%0d",
                       want.correct_total, got.correct_total,
                       want.muted_total, got.muted_total);
            end
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        fresh = classify_logits({logit_5_i, logit_4_i, logit_3_i, logit_2_i, logit_1_i,
                                 logit_0_i}, true_label_i);
        if (fresh.correct && correct_cnt != '1) correct_cnt = correct_cnt + 1'b1;
        if (fresh.muted && muted_cnt != '1) muted_cnt = muted_cnt + 1'b1;
        fresh.correct_total = correct_cnt;
        fresh.muted_total = muted_cnt;
        pending_verdicts.push_back(fresh);
      end
    end
    errors_o <= mismatches;
    pending_o <= pending_verdicts.size();
    checked_o <= checked;
  end

endmodule

/* sim/softmax_confidence_gate_tb.sv */
// Testbench top for the softmax confidence gate: clock, reset, item and
// register stimulus, result-side stalls, watchdog and the final verdict.
// Depends on scg_pkg, the block itself and softmax_gate_checker.

module softmax_confidence_gate_tb;
  import scg_pkg::*;

  localparam int RANDOM_ITEMS   = 900;
  localparam int PHASES         = 9;
  localparam int SETTLE_CYCLES  = 48;   // a little above one item's unstalled pass through the block
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic [NUM_LABELS-1:0][LOGIT_W-1:0] logit_set_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i    = '0;
  logic [Q16_W-1:0]     cfg_wdata_i  = '0;
  logic                 in_valid_i   = 1'b0;
  logic [LOGIT_W-1:0]   logit_0_i    = '0;
  logic [LOGIT_W-1:0]   logit_1_i    = '0;
  logic [LOGIT_W-1:0]   logit_2_i    = '0;
  logic [LOGIT_W-1:0]   logit_3_i    = '0;
  logic [LOGIT_W-1:0]   logit_4_i    = '0;
  logic [LOGIT_W-1:0]   logit_5_i    = '0;
  logic [LBL_W-1:0]     true_label_i = '0;
  logic                 out_stall_i  = 1'b0;

  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [LBL_W-1:0]     detected_label_o;
  logic [Q16_W-1:0]     uncertainty_o;
  logic [Q16_W-1:0]     strength_o;
  logic                 is_correct_o;
  logic                 is_muted_o;
  logic [CNT_W-1:0]     correct_total_o;
  logic [CNT_W-1:0]     muted_total_o;

  int errors;
  int pending;
  int checked;
  int items_sent     = 0;
  int settings_used  = 1;   // the reset defaults count as the first setting
  int quiet_cycles   = 0;
  bit in_burst       = 1'b0;
  bit out_burst      = 1'b0;

  softmax_confidence_gate dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .logit_0_i        (logit_0_i),
    .logit_1_i        (logit_1_i),
    .logit_2_i        (logit_2_i),
    .logit_3_i        (logit_3_i),
    .logit_4_i        (logit_4_i),
    .logit_5_i        (logit_5_i),
    .true_label_i     (true_label_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .detected_label_o (detected_label_o),
    .uncertainty_o    (uncertainty_o),
    .strength_o       (strength_o),
    .is_correct_o     (is_correct_o),
    .is_muted_o       (is_muted_o),
    .correct_total_o  (correct_total_o),
    .muted_total_o    (muted_total_o)
  );

  softmax_gate_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .logit_0_i        (logit_0_i),
    .logit_1_i        (logit_1_i),
    .logit_2_i        (logit_2_i),
    .logit_3_i        (logit_3_i),
    .logit_4_i        (logit_4_i),
    .logit_5_i        (logit_5_i),
    .true_label_i     (true_label_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .detected_label_i (detected_label_o),
    .uncertainty_i    (uncertainty_o),
    .strength_i       (strength_o),
    .is_correct_i     (is_correct_o),
    .is_muted_i       (is_muted_o),
    .correct_total_i  (correct_total_o),
    .muted_total_i    (muted_total_o),
    .errors_o         (errors),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Builds a logit set from six signed Q4.8 values, label 0 first.
  function automatic logit_set_t pack6(input int a, input int b, input int c,
                                       input int d, input int e, input int f);
    logit_set_t lg;
    lg[0] = a[LOGIT_W-1:0];
    lg[1] = b[LOGIT_W-1:0];
    lg[2] = c[LOGIT_W-1:0];
    lg[3] = d[LOGIT_W-1:0];
    lg[4] = e[LOGIT_W-1:0];
    lg[5] = f[LOGIT_W-1:0];
    return lg;
  endfunction

  // Random logits. Most items are clustered below a common peak so that the
  // uncertainty spreads over its whole range; the others are drawn across the
  // full field, which mostly gives confident items. Some items get a tie on
  // the peak and a few get the field extremes.
  function automatic logit_set_t draw_logits();
    logit_set_t lg;
    int         base;
    int         spread;
    int         v;
    int         i;
    int         j;
    int         k;
    bit         wide;
    wide = ($urandom_range(0, 3) == 0);
    base = int'($urandom_range(0, 4095)) - 2048;
    spread = $urandom_range(1, 1536);
    for (i = 0; i < NUM_LABELS; i++) begin
      if (wide) v = int'($urandom_range(0, 4095)) - 2048;
      else v = base - int'($urandom_range(0, spread));
      if ($urandom_range(0, 31) == 0) v = $urandom_range(0, 1) ? 2047 : -2048;
      if (v < -2048) v = -2048;
      lg[i] = v[LOGIT_W-1:0];
    end
    if ($urandom_range(0, 5) == 0) begin
      v = wide ? 2047 : base;
      j = $urandom_range(0, NUM_LABELS - 1);
      k = $urandom_range(0, NUM_LABELS - 1);
      lg[j] = v[LOGIT_W-1:0];
      lg[k] = v[LOGIT_W-1:0];
    end
    return lg;
  endfunction

  // True labels 6 and 7 never match a detection, so they are kept rare.
  function automatic logic [LBL_W-1:0] draw_truth();
    int t;
    if ($urandom_range(0, 15) == 0) t = $urandom_range(6, 7);
    else t = $urandom_range(0, NUM_LABELS - 1);
    return t[LBL_W-1:0];
  endfunction

  // Offers one item after a random idle gap and returns once it is accepted.
  // Valid stays high into the next item when that one draws no gap.
  task automatic send_item(input logit_set_t lg, input logic [LBL_W-1:0] truth);
    int gap;
    if ($urandom_range(0, 23) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    logit_0_i    <= lg[0];
    logit_1_i    <= lg[1];
    logit_2_i    <= lg[2];
    logit_3_i    <= lg[3];
    logit_4_i    <= lg[4];
    logit_5_i    <= lg[5];
    true_label_i <= truth;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q16_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // Writes all eight registers back to back; only called while the block is idle.
  task automatic apply_setting(input logic [Q16_W-1:0] thr, input logic [Q16_W-1:0] mut,
                               input logic [NUM_STR-1:0][Q16_W-1:0] str);
    logic [CFG_IDX_W-1:0] idx;
    int                   i;
    write_reg(CFG_THRESH, thr);
    write_reg(CFG_MUTED, mut);
    idx = CFG_STR0;
    for (i = 0; i < NUM_STR; i++) begin
      write_reg(idx, str[i]);
      idx = idx + 1'b1;
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Lowers valid, waits until every outstanding result is back, then lets
  // the block settle. The first edge lets the last acceptance show up in
  // the checker's outstanding count.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Result side: a random stall before each result, with stretches of none.
  // The stall is dropped and then held low until a result is taken.
  initial begin : result_sink
    int hold;
    forever begin
      if ($urandom_range(0, 23) == 0) out_burst = !out_burst;
      hold = out_burst ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Ends the run when neither channel nor the register port moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    logic [Q16_W-1:0]                 thr;
    logic [Q16_W-1:0]                 mut;
    logic [NUM_STR-1:0][Q16_W-1:0]    str;
    int                               p;
    int                               n;
    int                               i;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items under the reset defaults. All-equal logits give the
    // highest uncertainty and pick label 0; one peak at full scale against
    // the floor gives zero uncertainty, and with label 5 the zero default
    // strength.
    send_item(pack6(0, 0, 0, 0, 0, 0), 3'd0);
    send_item(pack6(2047, 2047, 2047, 2047, 2047, 2047), 3'd5);
    send_item(pack6(-2048, -2048, -2048, -2048, -2048, -2048), 3'd0);
    for (i = 0; i < NUM_LABELS; i++)
      send_item(pack6(i == 0 ? 2047 : -2048, i == 1 ? 2047 : -2048, i == 2 ? 2047 : -2048,
                      i == 3 ? 2047 : -2048, i == 4 ? 2047 : -2048, i == 5 ? 2047 : -2048),
                i[LBL_W-1:0]);
    // Tied maxima away from label 0: the lower index has to win.
    send_item(pack6(0, 100, -50, 300, 200, 300), 3'd3);
    send_item(pack6(-700, -900, -2048, -800, 512, 512), 3'd7);
    // Distances of exactly one natural unit, and ones that hit every table part.
    send_item(pack6(1791, 1791, 1791, 1791, 1791, 2047), 3'd6);
    send_item(pack6(1000, 999, 985, 984, 745, 760), 3'd1);
    // Distances past eleven units; from twelve on the integer exponent is zero.
    send_item(pack6(2047, -1025, -1100, -2048, -1500, -1024), 3'd0);
    // Alternating bit patterns.
    send_item(pack6(1365, -1366, 240, -241, 1, -1), 3'd2);
    // Just below and just above the default threshold, then well above it.
    send_item(pack6(0, -160, -2048, -2048, -2048, -2048), 3'd0);
    send_item(pack6(0, -155, -2048, -2048, -2048, -2048), 3'd1);
    send_item(pack6(-2048, 0, 0, -2048, -2048, -2048), 3'd1);
    send_item(pack6(-2048, -2048, -2048, -2048, 64, 0), 3'd4);
    drain();

    // Random phases. The first two use the register extremes: muted for every nonzero
    // uncertainty, with full muted strength, then never muted with full label strengths.
    for (p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        thr = '0;
        mut = '1;
        str = '0;
      end else if (p == 1) begin
        thr = '1;
        mut = '0;
        str = '1;
      end else begin
        // Keep most thresholds within the reachable uncertainty range.
        thr = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                          : 16'($urandom_range(0, 56000));
        mut = 16'($urandom_range(0, 65535));
        for (i = 0; i < NUM_STR; i++)
          str[i] = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                                               : 16'($urandom_range(0, 65535));
      end
      apply_setting(thr, mut, str);
      for (n = 0; n < RANDOM_ITEMS / PHASES; n++)
        send_item(draw_logits(), draw_truth());
      drain();
    end

    $display("Summary: %0d items sent under %0d register settings, %0d results checked.",
             items_sent, settings_used, checked);
    $display("Summary: %0d mismatches counted.", errors);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* softmax_confidence_gate.f */
sv/scg_pkg.sv
sv/scg_div.sv
sv/softmax_confidence_gate.sv
sim/softmax_gate_checker.sv
sim/softmax_confidence_gate_tb.sv
